// ----- hw/rtl/src_pkg.sv -----
// shared types, constants and helper functions of the sensor compensation pipeline
package src_pkg;

   // calibration coefficients as raw bit slices
   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [15:0] t3;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [15:0] p3;
      logic [15:0] p4;
      logic [15:0] p5;
      logic [15:0] p6;
      logic [15:0] p7;
      logic [15:0] p8;
      logic [15:0] p9;
      logic [7:0]  h1;
      logic [15:0] h2;
      logic [7:0]  h3;
      logic [11:0] h4;
      logic [11:0] h5;
      logic [7:0]  h6;
   } coef_type;

   // partial products of a 64-bit by 17-bit product, modulo 2^64
   typedef struct packed {
      logic [63:0] low;
      logic [31:0] high;
   } part_type;

   // calibration register indexes (byte address bits 5:3)
   localparam logic [2:0] REG_CALIB_TEMP       = 3'd0;
   localparam logic [2:0] REG_CALIB_PRESS_LOW  = 3'd1;
   localparam logic [2:0] REG_CALIB_PRESS_HIGH = 3'd2;
   localparam logic [2:0] REG_CALIB_PRESS_LAST = 3'd3;
   localparam logic [2:0] REG_CALIB_HUMIDITY   = 3'd4;

   // fixed constants of the compensation formulas
   localparam logic [33:0] C_FINE_PRESS   = 34'd128000;
   localparam logic [20:0] C_PRESS_BASE   = 21'd1048576;
   localparam logic [16:0] C_PRESS_SCALE  = 17'd3125;
   localparam logic [31:0] C_FINE_HUM     = 32'd76800;
   localparam logic [31:0] C_HUM_MAX      = 32'd419430400;
   localparam logic [31:0] C_HUM_ROUND    = 32'd16384;
   localparam logic [31:0] C_HUM_OFFSET   = 32'd2097152;
   localparam logic [31:0] C_HUM_HALF     = 32'd32768;
   localparam logic [31:0] C_HUM_ROUND2   = 32'd8192;
   localparam logic [63:0] C_BIAS_47      = 64'h0000_8000_0000_0000;
   localparam logic [16:0] HUM_OUT_MAX    = 17'd102400;

   // stage counts of the pipeline sections
   localparam int unsigned DIV_BITS  = 64;
   localparam int unsigned FRONT_LAT = 5;
   localparam int unsigned PREP_LAT  = 6;
   localparam int unsigned DIV_LAT   = DIV_BITS + 2;
   localparam int unsigned POST_LAT  = 5;
   localparam int unsigned HUM_LAT   = 10;

   // split a * sext(c) mod 2^64 into two 32-bit-wide products
   function automatic part_type mul_part(input logic [63:0] a, input logic [16:0] c);
      logic [31:0] c_lo;
      logic [31:0] fix;
      part_type    r;
      c_lo   = 32'($signed(c));
      fix    = c[16] ? a[31:0] : 32'd0;
      r.low  = {32'd0, a[31:0]} * {32'd0, c_lo};
      r.high = a[63:32] * c_lo - fix;
      return r;
   endfunction

   // recombine the partial products
   function automatic logic [63:0] part_sum(input part_type p);
      return p.low + {p.high, 32'd0};
   endfunction

endpackage

// ----- hw/rtl/sensor_reading_compensation_top.sv -----
// top level: calibration registers, pipeline sections, result register
// Compensates one raw temperature/pressure/humidity set per clock; a held result stalls
// the whole pipeline. A request is taken in every cycle in which the result register is
// empty or being drained, and its result passes 5 temperature stages, 6 pressure
// preparation stages, 66 stages of the bit-per-stage 64-bit divider, 5 pressure
// correction stages and the result register. Calibration registers sit at byte
// addresses 0, 8, 16, 24 and 32; the user must write them only while no request is in
// flight, as the block itself does not enforce it.
module sensor_reading_compensation_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [19:0]        req_temp_code,
   input  logic [19:0]        req_press_code,
   input  logic [15:0]        req_hum_code,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_temperature_centi,
   output logic [31:0]        rsp_pressure_q24_8,
   output logic               rsp_pressure_invalid,
   output logic [16:0]        rsp_humidity_q22_10,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [5:0]         paddr,
   input  logic [63:0]        pwdata,
   output logic [63:0]        prdata,
   output logic               pready
);

   localparam int unsigned TEMP_DEPTH = src_pkg::PREP_LAT + src_pkg::DIV_LAT
                                        + src_pkg::POST_LAT;
   localparam int unsigned HUM_DEPTH  = TEMP_DEPTH - src_pkg::HUM_LAT;
   localparam int unsigned ZERO_DEPTH = src_pkg::DIV_LAT + src_pkg::POST_LAT;

   logic [47:0]       calib_temp_ff;
   logic [63:0]       calib_press_low_ff, calib_press_high_ff, calib_humidity_ff;
   logic [15:0]       calib_press_last_ff;
   logic              csr_write;
   src_pkg::coef_type coef;
   logic              enable;

   logic              front_valid, prep_valid, div_valid, post_valid;
   logic [31:0]       front_temp, front_hv;
   logic [33:0]       front_v1;
   logic [19:0]       front_adc_p;
   logic [15:0]       front_adc_h;
   logic [63:0]       prep_num, prep_den, div_q, post_press;
   logic              prep_zero, zero_d;
   logic [16:0]       hum, hum_d;
   logic [31:0]       temp_d;

   logic              rsp_valid_ff;
   logic signed [31:0] rsp_temp_ff;
   logic [31:0]       rsp_press_ff, rsp_press_in;
   logic              rsp_inv_ff;
   logic [16:0]       rsp_hum_ff;

   // configuration port
   assign csr_write = psel & penable & pwrite & pready;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         calib_temp_ff       <= '0;
         calib_press_low_ff  <= '0;
         calib_press_high_ff <= '0;
         calib_press_last_ff <= '0;
         calib_humidity_ff   <= '0;
      end else if (csr_write) begin
         case (paddr[5:3])
            src_pkg::REG_CALIB_TEMP:       calib_temp_ff       <= pwdata[47:0];
            src_pkg::REG_CALIB_PRESS_LOW:  calib_press_low_ff  <= pwdata;
            src_pkg::REG_CALIB_PRESS_HIGH: calib_press_high_ff <= pwdata;
            src_pkg::REG_CALIB_PRESS_LAST: calib_press_last_ff <= pwdata[15:0];
            src_pkg::REG_CALIB_HUMIDITY:   calib_humidity_ff   <= pwdata;
            default: ;
         endcase
      end
   end

   // register read back
   always_comb begin
      case (paddr[5:3])
         src_pkg::REG_CALIB_TEMP:       prdata = {16'd0, calib_temp_ff};
         src_pkg::REG_CALIB_PRESS_LOW:  prdata = calib_press_low_ff;
         src_pkg::REG_CALIB_PRESS_HIGH: prdata = calib_press_high_ff;
         src_pkg::REG_CALIB_PRESS_LAST: prdata = {48'd0, calib_press_last_ff};
         src_pkg::REG_CALIB_HUMIDITY:   prdata = calib_humidity_ff;
         default:                       prdata = 64'd0;
      endcase
   end

   // coefficient slices
   assign coef.t1 = calib_temp_ff[15:0];
   assign coef.t2 = calib_temp_ff[31:16];
   assign coef.t3 = calib_temp_ff[47:32];
   assign coef.p1 = calib_press_low_ff[15:0];
   assign coef.p2 = calib_press_low_ff[31:16];
   assign coef.p3 = calib_press_low_ff[47:32];
   assign coef.p4 = calib_press_low_ff[63:48];
   assign coef.p5 = calib_press_high_ff[15:0];
   assign coef.p6 = calib_press_high_ff[31:16];
   assign coef.p7 = calib_press_high_ff[47:32];
   assign coef.p8 = calib_press_high_ff[63:48];
   assign coef.p9 = calib_press_last_ff;
   assign coef.h1 = calib_humidity_ff[7:0];
   assign coef.h2 = calib_humidity_ff[23:8];
   assign coef.h3 = calib_humidity_ff[31:24];
   assign coef.h4 = calib_humidity_ff[43:32];
   assign coef.h5 = calib_humidity_ff[55:44];
   assign coef.h6 = calib_humidity_ff[63:56];

   // the pipeline moves whenever the result register can take a new value
   assign enable    = ~rsp_valid_ff | rsp_ready;
   assign req_ready = enable;

   src_front u_front (
      .clock       (clock),
      .reset       (reset),
      .enable      (enable),
      .coef        (coef),
      .in_valid    (req_valid),
      .temp_code   (req_temp_code),
      .press_code  (req_press_code),
      .hum_code    (req_hum_code),
      .out_valid   (front_valid),
      .temperature (front_temp),
      .v1          (front_v1),
      .hv          (front_hv),
      .adc_p       (front_adc_p),
      .adc_h       (front_adc_h)
   );

   src_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .coef      (coef),
      .in_valid  (front_valid),
      .v1        (front_v1),
      .adc_p     (front_adc_p),
      .out_valid (prep_valid),
      .num       (prep_num),
      .den       (prep_den),
      .den_zero  (prep_zero)
   );

   src_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (prep_valid),
      .num       (prep_num),
      .den       (prep_den),
      .out_valid (div_valid),
      .quotient  (div_q)
   );

   src_post u_post (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .coef      (coef),
      .in_valid  (div_valid),
      .p         (div_q),
      .out_valid (post_valid),
      .press     (post_press)
   );

   src_humid u_humid (
      .clock    (clock),
      .enable   (enable),
      .coef     (coef),
      .hv       (front_hv),
      .adc_h    (front_adc_h),
      .humidity (hum)
   );

   // side results kept in step with the pressure path
   src_delay #(.WIDTH(32), .DEPTH(TEMP_DEPTH)) u_temp_delay (
      .clock  (clock),
      .enable (enable),
      .din    (front_temp),
      .dout   (temp_d)
   );

   src_delay #(.WIDTH(17), .DEPTH(HUM_DEPTH)) u_hum_delay (
      .clock  (clock),
      .enable (enable),
      .din    (hum),
      .dout   (hum_d)
   );

   src_delay #(.WIDTH(1), .DEPTH(ZERO_DEPTH)) u_zero_delay (
      .clock  (clock),
      .enable (enable),
      .din    (prep_zero),
      .dout   (zero_d)
   );

   // pressure saturation
   always_comb begin
      if (zero_d || post_press[63]) begin
         rsp_press_in = 32'd0;
      end else if (post_press[63:32] != 32'd0) begin
         rsp_press_in = 32'hFFFF_FFFF;
      end else begin
         rsp_press_in = post_press[31:0];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= post_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_temp_ff  <= $signed(temp_d);
         rsp_press_ff <= rsp_press_in;
         rsp_inv_ff   <= zero_d;
         rsp_hum_ff   <= hum_d;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_temperature_centi = rsp_temp_ff;
   assign rsp_pressure_q24_8    = rsp_press_ff;
   assign rsp_pressure_invalid  = rsp_inv_ff;
   assign rsp_humidity_q22_10   = rsp_hum_ff;

`ifndef NO_ASSERTIONS
   // a zero divisor always forces the pressure to zero
   a_invalid_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pressure_invalid |-> rsp_pressure_q24_8 == 32'd0)
      else $error("pressure not zero on invalid result");

   // humidity clamp holds
   a_hum_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_humidity_q22_10 <= src_pkg::HUM_OUT_MAX)
      else $error("humidity above full scale");
`endif

endmodule

// ----- hw/rtl/src_delay.sv -----
// fixed-length register line that keeps side data aligned with the pipeline
module src_delay #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   // shift on every pipeline advance
   always_ff @(posedge clock) begin
      if (enable) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

// ----- hw/rtl/src_front.sv -----
// temperature section: fine temperature term, centi-degree result, downstream seeds
module src_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  src_pkg::coef_type coef,
   input  logic              in_valid,
   input  logic [19:0]       temp_code,
   input  logic [19:0]       press_code,
   input  logic [15:0]       hum_code,
   output logic              out_valid,
   output logic [31:0]       temperature,
   output logic [33:0]       v1,
   output logic [31:0]       hv,
   output logic [19:0]       adc_p,
   output logic [15:0]       adc_h
);

   logic [4:0]  vld_ff;
   logic [19:0] p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic [15:0] h1_ff, h2_ff, h3_ff, h4_ff, h5_ff;
   logic [31:0] a_ff, a_in, b_ff, b_in;
   logic [31:0] at_ff, at_in, bb_ff, bb_in;
   logic [31:0] x_ff, x_in, y_ff, y_in;
   logic [31:0] fine_ff, fine_in;
   logic [31:0] temp_ff, temp_in, hv_ff, hv_in;
   logic [33:0] v1_ff, v1_in;

   // stage 1: offsets against t1
   assign a_in = 32'(temp_code >> 3) - 32'({coef.t1, 1'b0});
   assign b_in = 32'(temp_code >> 4) - 32'(coef.t1);
   // stage 2: products
   assign at_in = a_ff * 32'($signed(coef.t2));
   assign bb_in = b_ff * b_ff;
   // stage 3: scale and second product
   assign x_in = 32'($signed(at_ff) >>> 11);
   assign y_in = 32'($signed(bb_ff) >>> 12) * 32'($signed(coef.t3));
   // stage 4: fine temperature
   assign fine_in = x_ff + 32'($signed(y_ff) >>> 14);
   // stage 5: temperature and seeds for pressure and humidity
   assign temp_in = 32'($signed(fine_ff * 32'd5 + 32'd128) >>> 8);
   assign v1_in   = 34'($signed(fine_ff)) - src_pkg::C_FINE_PRESS;
   assign hv_in   = fine_ff - src_pkg::C_FINE_HUM;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (enable) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         p1_ff   <= press_code;
         h1_ff   <= hum_code;
         at_ff   <= at_in;
         bb_ff   <= bb_in;
         p2_ff   <= p1_ff;
         h2_ff   <= h1_ff;
         x_ff    <= x_in;
         y_ff    <= y_in;
         p3_ff   <= p2_ff;
         h3_ff   <= h2_ff;
         fine_ff <= fine_in;
         p4_ff   <= p3_ff;
         h4_ff   <= h3_ff;
         temp_ff <= temp_in;
         v1_ff   <= v1_in;
         hv_ff   <= hv_in;
         p5_ff   <= p4_ff;
         h5_ff   <= h4_ff;
      end
   end

   assign out_valid   = vld_ff[4];
   assign temperature = temp_ff;
   assign v1          = v1_ff;
   assign hv          = hv_ff;
   assign adc_p       = p5_ff;
   assign adc_h       = h5_ff;

endmodule

// ----- hw/rtl/src_prep.sv -----
// pressure section before the division: builds dividend and divisor
module src_prep (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  src_pkg::coef_type coef,
   input  logic              in_valid,
   input  logic [33:0]       v1,
   input  logic [19:0]       adc_p,
   output logic              out_valid,
   output logic [63:0]       num,
   output logic [63:0]       den,
   output logic              den_zero
);

   logic [5:0]        vld_ff;
   logic [19:0]       ap1_ff, ap2_ff, ap3_ff;
   logic [63:0]       sq_ff, sq_in, v1p5_ff, v1p5_in, v1p2_ff, v1p2_in;
   logic [63:0]       v1p5b_ff, v1p2b_ff;
   src_pkg::part_type part6_ff, part6_in, part3_ff, part3_in;
   logic [63:0]       v2_ff, v2_in, v1b_ff, v1b_in;
   logic [63:0]       t_ff, t_in, nd_ff, nd_in;
   logic [20:0]       pp;
   src_pkg::part_type partt_ff, partt_in, partn_ff, partn_in;
   logic [63:0]       den_ff, den_in, num_ff, num_in;
   logic              zero_ff;

   // stage 1: square and linear terms
   assign sq_in   = 64'($signed(v1)) * 64'($signed(v1));
   assign v1p5_in = 64'($signed(v1)) * 64'($signed(coef.p5));
   assign v1p2_in = 64'($signed(v1)) * 64'($signed(coef.p2));
   // stage 2: square times p6 and p3
   assign part6_in = src_pkg::mul_part(sq_ff, {coef.p6[15], coef.p6});
   assign part3_in = src_pkg::mul_part(sq_ff, {coef.p3[15], coef.p3});
   // stage 3: sum the terms
   assign v2_in  = src_pkg::part_sum(part6_ff) + (v1p5b_ff << 17)
                   + (64'($signed(coef.p4)) << 35);
   assign v1b_in = 64'($signed(src_pkg::part_sum(part3_ff)) >>> 8) + (v1p2b_ff << 12);
   // stage 4: bias and raw-pressure term
   assign pp    = src_pkg::C_PRESS_BASE - 21'(ap3_ff);
   assign t_in  = src_pkg::C_BIAS_47 + v1b_ff;
   assign nd_in = (64'(pp) << 31) - v2_ff;
   // stage 5: scale both
   assign partt_in = src_pkg::mul_part(t_ff, {1'b0, coef.p1});
   assign partn_in = src_pkg::mul_part(nd_ff, src_pkg::C_PRESS_SCALE);
   // stage 6: divisor and dividend
   assign den_in = 64'($signed(src_pkg::part_sum(partt_ff)) >>> 33);
   assign num_in = src_pkg::part_sum(partn_ff);

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[4:0], in_valid};
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (enable) begin
         sq_ff    <= sq_in;
         v1p5_ff  <= v1p5_in;
         v1p2_ff  <= v1p2_in;
         ap1_ff   <= adc_p;
         part6_ff <= part6_in;
         part3_ff <= part3_in;
         v1p5b_ff <= v1p5_ff;
         v1p2b_ff <= v1p2_ff;
         ap2_ff   <= ap1_ff;
         v2_ff    <= v2_in;
         v1b_ff   <= v1b_in;
         ap3_ff   <= ap2_ff;
         t_ff     <= t_in;
         nd_ff    <= nd_in;
         partt_ff <= partt_in;
         partn_ff <= partn_in;
         den_ff   <= den_in;
         num_ff   <= num_in;
         zero_ff  <= (den_in == 64'd0);
      end
   end

   assign out_valid = vld_ff[5];
   assign num       = num_ff;
   assign den       = den_ff;
   assign den_zero  = zero_ff;

endmodule

// ----- hw/rtl/src_divider.sv -----
// pipelined signed 64-bit divider, one quotient bit per stage, truncating toward zero
module src_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        enable,
   input  logic        in_valid,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic        out_valid,
   output logic [63:0] quotient
);

   localparam int unsigned N = src_pkg::DIV_BITS;

   logic [63:0] rem_ff [N+1];
   logic [63:0] quo_ff [N+1];
   logic [63:0] den_ff [N+1];
   logic        neg_ff [N+1];
   logic [N:0]  vld_ff;
   logic        out_vld_ff;
   logic [63:0] q_ff, q_in;

   // magnitude stage
   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= 64'd0;
         quo_ff[0] <= num[63] ? 64'd0 - num : num;
         den_ff[0] <= den[63] ? 64'd0 - den : den;
         neg_ff[0] <= num[63] ^ den[63];
      end
   end

   // restoring steps
   for (genvar k = 1; k <= N; k++) begin : g_step
      logic [64:0] trial;
      logic        fit;
      logic [63:0] rem_in;
      assign trial  = {rem_ff[k-1], quo_ff[k-1][63]} - {1'b0, den_ff[k-1]};
      assign fit    = ~trial[64];
      assign rem_in = fit ? trial[63:0] : {rem_ff[k-1][62:0], quo_ff[k-1][63]};
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k] <= rem_in;
            quo_ff[k] <= {quo_ff[k-1][62:0], fit};
            den_ff[k] <= den_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
         end
      end
   end

   // sign fix
   assign q_in = neg_ff[N] ? 64'd0 - quo_ff[N] : quo_ff[N];

   always_ff @(posedge clock) begin
      if (enable) begin
         q_ff <= q_in;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (enable) begin
         vld_ff     <= {vld_ff[N-1:0], in_valid};
         out_vld_ff <= vld_ff[N];
      end
   end

   assign out_valid = out_vld_ff;
   assign quotient  = q_ff;

endmodule

// ----- hw/rtl/src_post.sv -----
// pressure section after the division: quadratic correction and offset
module src_post (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  src_pkg::coef_type coef,
   input  logic              in_valid,
   input  logic [63:0]       p,
   output logic              out_valid,
   output logic [63:0]       press
);

   logic [4:0]        vld_ff;
   logic [63:0]       q;
   logic [63:0]       ll_ff, ll_in;
   logic [31:0]       lh_ff, lh_in;
   src_pkg::part_type part8_ff, part8_in, part9_ff, part9_in;
   logic [63:0]       pa_ff, pb_ff, pc_ff, pd_ff;
   logic [63:0]       qq_ff, qq_in, v2_ff, v2_in, v2b_ff, v2c_ff;
   logic [63:0]       v1_ff, v1_in;
   logic [63:0]       sum_ff, sum_in;

   // stage 1: q squared in halves, p times p8
   assign q        = 64'($signed(p) >>> 13);
   assign ll_in    = {32'd0, q[31:0]} * {32'd0, q[31:0]};
   assign lh_in    = q[31:0] * q[63:32];
   assign part8_in = src_pkg::mul_part(p, {coef.p8[15], coef.p8});
   // stage 2: combine
   assign qq_in = ll_ff + {lh_ff[30:0], 33'd0};
   assign v2_in = 64'($signed(src_pkg::part_sum(part8_ff)) >>> 19);
   // stage 3: times p9
   assign part9_in = src_pkg::mul_part(qq_ff, {coef.p9[15], coef.p9});
   // stage 4: combine
   assign v1_in = 64'($signed(src_pkg::part_sum(part9_ff)) >>> 25);
   // stage 5: final sum with p7 offset
   assign sum_in = 64'($signed(pd_ff + v1_ff + v2c_ff) >>> 8) + (64'($signed(coef.p7)) << 4);

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (enable) begin
         ll_ff    <= ll_in;
         lh_ff    <= lh_in;
         part8_ff <= part8_in;
         pa_ff    <= p;
         qq_ff    <= qq_in;
         v2_ff    <= v2_in;
         pb_ff    <= pa_ff;
         part9_ff <= part9_in;
         v2b_ff   <= v2_ff;
         pc_ff    <= pb_ff;
         v1_ff    <= v1_in;
         v2c_ff   <= v2b_ff;
         pd_ff    <= pc_ff;
         sum_ff   <= sum_in;
      end
   end

   assign out_valid = vld_ff[4];
   assign press     = sum_ff;

endmodule

// ----- hw/rtl/src_humid.sv -----
// humidity section: 32-bit wrapping arithmetic, clamp and Q22.10 result
module src_humid (
   input  logic              clock,
   input  logic              enable,
   input  src_pkg::coef_type coef,
   input  logic [31:0]       hv,
   input  logic [15:0]       adc_h,
   output logic [16:0]       humidity
);

   logic [15:0] ah_ff;
   logic [31:0] m1_ff, m1_in, m2_ff, m2_in, m3_ff, m3_in;
   logic [31:0] hx2_ff, hx2_in, hx3_ff, hx4_ff, hx5_ff, hx6_ff;
   logic [31:0] ya_ff, ya_in, yb_ff, yb_in;
   logic [31:0] ym_ff, ym_in, hy_ff, hy_in, hm_ff, hm_in, hy2_ff, hy2_in;
   logic [31:0] hvv_ff, hvv_in, hvv2_ff, hvv3_ff;
   logic [31:0] hs;
   logic [31:0] hss_ff, hss_in, m_ff, m_in;
   logic [31:0] hfin;
   logic [16:0] hum_ff, hum_in;

   // stage 1: products with the fine term
   assign m1_in = 32'($signed(coef.h5)) * hv;
   assign m2_in = hv * 32'($signed(coef.h6));
   assign m3_in = hv * 32'(coef.h3);
   // stage 2: x term and y factors
   assign hx2_in = 32'($signed((32'(ah_ff) << 14) - (32'($signed(coef.h4)) << 20)
                   - m1_ff + src_pkg::C_HUM_ROUND) >>> 15);
   assign ya_in  = 32'($signed(m2_ff) >>> 10);
   assign yb_in  = 32'($signed(m3_ff) >>> 11) + src_pkg::C_HUM_HALF;
   // stages 3 to 6: y term
   assign ym_in  = ya_ff * yb_ff;
   assign hy_in  = 32'($signed(ym_ff) >>> 10) + src_pkg::C_HUM_OFFSET;
   assign hm_in  = hy_ff * 32'($signed(coef.h2));
   assign hy2_in = 32'($signed(hm_ff + src_pkg::C_HUM_ROUND2) >>> 14);
   // stage 7: x times y
   assign hvv_in = hx6_ff * hy2_ff;
   // stages 8 and 9: h1 correction
   assign hs     = 32'($signed(hvv_ff) >>> 15);
   assign hss_in = hs * hs;
   assign m_in   = 32'($signed(hss_ff) >>> 7) * 32'(coef.h1);
   // stage 10: subtract, clamp, scale
   assign hfin = hvv3_ff - 32'($signed(m_ff) >>> 4);

   always_comb begin
      if (hfin[31]) begin
         hum_in = 17'd0;
      end else if (hfin > src_pkg::C_HUM_MAX) begin
         hum_in = 17'(src_pkg::C_HUM_MAX >> 12);
      end else begin
         hum_in = 17'(hfin >> 12);
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (enable) begin
         m1_ff   <= m1_in;
         m2_ff   <= m2_in;
         m3_ff   <= m3_in;
         ah_ff   <= adc_h;
         hx2_ff  <= hx2_in;
         ya_ff   <= ya_in;
         yb_ff   <= yb_in;
         ym_ff   <= ym_in;
         hx3_ff  <= hx2_ff;
         hy_ff   <= hy_in;
         hx4_ff  <= hx3_ff;
         hm_ff   <= hm_in;
         hx5_ff  <= hx4_ff;
         hy2_ff  <= hy2_in;
         hx6_ff  <= hx5_ff;
         hvv_ff  <= hvv_in;
         hss_ff  <= hss_in;
         hvv2_ff <= hvv_ff;
         m_ff    <= m_in;
         hvv3_ff <= hvv2_ff;
         hum_ff  <= hum_in;
      end
   end

   assign humidity = hum_ff;

endmodule
